// ===== hw/rtl/pve_pkg.sv =====
// pve_pkg: shared types and constants of the pointer velocity estimator
// holds the controller state and datapath op enums, the status struct and fixed-point constants
// no dependencies
`default_nettype none

package pve_pkg;

   localparam int SPEED_W = 39;
   localparam int VEL_W   = 40;
   localparam int CSR_IDX_W = 8;
   localparam int CSR_DAT_W = 16;
   localparam int SQRT_RAD_W = 82;
   localparam int SQRT_ROOT_W = SQRT_RAD_W / 2;

   localparam logic [SPEED_W-1:0] SPEED_MAX  = {SPEED_W{1'b1}};
   localparam logic [31:0]        E1_Q32     = 32'd1580030169;
   localparam logic [21:0]        INST_SCALE = 22'd4096000;
   localparam logic [19:0]        R_LIMIT    = 20'hC0000;
   localparam logic [3:0]         TERM_LAST  = 4'd12;
   localparam logic [16:0]        K_ONE      = 17'd65536;

   localparam logic [CSR_DAT_W-1:0] NFT_RESET = 16'd267;
   localparam logic [CSR_DAT_W-1:0] TAU_RESET = 16'd800;

   localparam logic [CSR_IDX_W-1:0] CSR_NOMINAL_FRAME_TIME     = 8'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_VELOCITY_TIME_CONSTANT = 8'd1;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_DECIDE,
      ST_R_WAIT,
      ST_T_MUL,
      ST_T_MUL_W,
      ST_T_DIV_W,
      ST_E_INIT,
      ST_E_CHK,
      ST_E_MUL_W,
      ST_V_MUL,
      ST_V_MUL_W,
      ST_V_DIV_W,
      ST_B_MUL_W,
      ST_SQ_X,
      ST_SQ_X_W,
      ST_SQ_Y_W,
      ST_SQRT_W,
      ST_FINISH
   } pve_state_type;

   typedef enum logic [4:0] {
      OP_NONE,
      OP_LOAD,
      OP_FIRST,
      OP_START_R,
      OP_K_ONE,
      OP_R_TAKE,
      OP_T_MUL,
      OP_T_DIV,
      OP_T_ACC,
      OP_E_INIT,
      OP_E_MUL,
      OP_E_TAKE,
      OP_K_CALC,
      OP_V_MUL,
      OP_V_DIV,
      OP_B_MUL,
      OP_B_UPD,
      OP_SQ_X,
      OP_SQ_Y,
      OP_SQRT,
      OP_FINISH
   } pve_op_type;

   typedef struct packed {
      logic first_case;
      logic dt_zero;
      logic tau_zero;
      logic r_big;
      logic terms_last;
      logic n_zero;
      logic axis_y;
      logic mul_done;
      logic div_done;
      logic sqrt_done;
      logic out_free;
   } pve_status_type;

endpackage

`default_nettype wire

// ===== hw/rtl/pointer_velocity_ema.sv =====
// pointer_velocity_ema: top level of the smoothed pointer velocity estimator
// depends on pve_pkg, pve_ctrl and pve_dp
//
// Takes one pointer sample at a time (position plus elapsed time) and returns one result per
// sample: the smoothed velocity in Q28.12 px/s and its saturated magnitude. All arithmetic runs
// through one bit-serial multiplier, one bit-serial divider and a two-bit-per-cycle square root,
// sequenced by a controller, so a sample is accepted only while the block is idle. The full
// blend path adds a ratio division, twelve series terms and up to eleven scaling steps. The
// result waits in an output register and the next sample is taken while it waits.
// Configuration writes are taken in any cycle.
`default_nettype none

module pointer_velocity_ema #(
   parameter int POS_BITS  = 16,
   parameter int TIME_BITS = 16
) (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     req_tvalid,
   output logic                                     req_tready,
   // pos_x, pos_y, elapsed, zero pad
   input  logic [((2*POS_BITS+TIME_BITS+7)/8)*8-1:0] req_tdata,
   // restart
   input  logic                                     req_tuser,
   output logic                                     rsp_tvalid,
   input  logic                                     rsp_tready,
   // speed, vel_x_out, vel_y_out, zero pad
   output logic [119:0]                             rsp_tdata,
   // first_sample
   output logic                                     rsp_tuser,
   input  logic                                     csr_valid,
   output logic                                     csr_ready,
   input  logic [pve_pkg::CSR_IDX_W-1:0]            csr_index,
   input  logic [pve_pkg::CSR_DAT_W-1:0]            csr_data
);
   import pve_pkg::*;

   pve_op_type              op;
   pve_status_type          status;
   logic [SPEED_W-1:0]      speed;
   logic [VEL_W-1:0]        vel_x_out;
   logic [VEL_W-1:0]        vel_y_out;
   logic signed [POS_BITS-1:0] pos_x;
   logic signed [POS_BITS-1:0] pos_y;
   logic [TIME_BITS-1:0]    elapsed;

   assign pos_x   = req_tdata[POS_BITS-1:0];
   assign pos_y   = req_tdata[2*POS_BITS-1:POS_BITS];
   assign elapsed = req_tdata[2*POS_BITS+TIME_BITS-1:2*POS_BITS];

   assign csr_ready = 1'b1;

   pve_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .op         (op)
   );

   pve_dp #(.POS_BITS(POS_BITS), .TIME_BITS(TIME_BITS)) u_dp (
      .clock        (clock),
      .reset        (reset),
      .op           (op),
      .status       (status),
      .pos_x        (pos_x),
      .pos_y        (pos_y),
      .elapsed      (elapsed),
      .restart      (req_tuser),
      .csr_valid    (csr_valid),
      .csr_index    (csr_index),
      .csr_data     (csr_data),
      .rsp_tready   (rsp_tready),
      .rsp_tvalid   (rsp_tvalid),
      .speed        (speed),
      .vel_x_out    (vel_x_out),
      .vel_y_out    (vel_y_out),
      .first_sample (rsp_tuser)
   );

   assign rsp_tdata = {1'b0, vel_y_out, vel_x_out, speed};

endmodule

`default_nettype wire

// ===== hw/rtl/pve_mul.sv =====
// pve_mul: shift-and-add unsigned multiplier, one bit of b per cycle
// used by pve_dp for every product of the estimator; no package use
`default_nettype none

module pve_mul #(
   parameter int AW = 41,
   parameter int BW = 41
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [AW-1:0]    a,
   input  logic [BW-1:0]    b,
   output logic             done,
   output logic [AW+BW-1:0] prod
);
   localparam int PW = AW + BW;
   localparam int CW = $clog2(BW + 1);

   logic          busy_ff, busy_in;
   logic          done_ff, done_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [PW-1:0] acc_ff, acc_in;
   logic [PW-1:0] a_ff, a_in;
   logic [BW-1:0] b_ff, b_in;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      acc_in  = acc_ff;
      a_in    = a_ff;
      b_in    = b_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CW'(BW);
         acc_in  = '0;
         a_in    = PW'(a);
         b_in    = b;
      end else if (busy_ff) begin
         if (b_ff[0]) begin
            acc_in = acc_ff + a_ff;
         end
         a_in   = a_ff << 1;
         b_in   = b_ff >> 1;
         cnt_in = cnt_ff - CW'(1);
         if (cnt_ff == CW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff <= cnt_in;
      acc_ff <= acc_in;
      a_ff   <= a_in;
      b_ff   <= b_in;
   end

   assign done = done_ff;
   assign prod = acc_ff;

endmodule

`default_nettype wire

// ===== hw/rtl/pve_div.sv =====
// pve_div: restoring unsigned divider, one quotient bit per cycle
// used by pve_dp for the time ratio, the series terms and the velocity; no package use
`default_nettype none

module pve_div #(
   parameter int NW = 40,
   parameter int DW = 17
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   input  logic [NW-1:0] num,
   input  logic [DW-1:0] den,
   output logic          done,
   output logic [NW-1:0] quo
);
   localparam int CW = $clog2(NW + 1);

   logic          busy_ff, busy_in;
   logic          done_ff, done_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [DW-1:0] rem_ff, rem_in;
   logic [NW-1:0] quo_ff, quo_in;
   logic [DW-1:0] den_ff, den_in;
   logic [DW:0]   trial;
   logic [DW:0]   diff;
   logic          ge;

   always_comb begin
      trial = {rem_ff, quo_ff[NW-1]};
      diff  = trial - {1'b0, den_ff};
      ge    = (trial >= {1'b0, den_ff});
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      den_in  = den_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CW'(NW);
         rem_in  = '0;
         quo_in  = num;
         den_in  = den;
      end else if (busy_ff) begin
         rem_in = ge ? diff[DW-1:0] : trial[DW-1:0];
         quo_in = {quo_ff[NW-2:0], ge};
         cnt_in = cnt_ff - CW'(1);
         if (cnt_ff == CW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff <= cnt_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      den_ff <= den_in;
   end

   assign done = done_ff;
   assign quo  = quo_ff;

endmodule

`default_nettype wire

// ===== hw/rtl/pve_sqrt.sv =====
// pve_sqrt: digit-by-digit integer square root, two radicand bits per cycle
// used by pve_dp for the speed magnitude; no package use
`default_nettype none

module pve_sqrt #(
   parameter int RW = 82
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            start,
   input  logic [RW-1:0]   rad,
   output logic            done,
   output logic [RW/2-1:0] root
);
   localparam int QW = RW / 2;
   localparam int CW = $clog2(QW + 1);

   logic          busy_ff, busy_in;
   logic          done_ff, done_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [RW-1:0] rad_ff, rad_in;
   logic [QW+1:0] rem_ff, rem_in;
   logic [QW-1:0] root_ff, root_in;
   logic [QW+3:0] sh;
   logic [QW+3:0] trial;
   logic [QW+3:0] diff;
   logic          ge;

   always_comb begin
      sh    = {rem_ff, rad_ff[RW-1:RW-2]};
      trial = (QW+4)'({root_ff, 2'b01});
      diff  = sh - trial;
      ge    = (sh >= trial);
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rad_in  = rad_ff;
      rem_in  = rem_ff;
      root_in = root_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CW'(QW);
         rad_in  = rad;
         rem_in  = '0;
         root_in = '0;
      end else if (busy_ff) begin
         rem_in  = ge ? diff[QW+1:0] : sh[QW+1:0];
         root_in = {root_ff[QW-2:0], ge};
         rad_in  = rad_ff << 2;
         cnt_in  = cnt_ff - CW'(1);
         if (cnt_ff == CW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff  <= cnt_in;
      rad_ff  <= rad_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
   end

   assign done = done_ff;
   assign root = root_ff;

endmodule

`default_nettype wire

// ===== hw/rtl/pve_ctrl.sv =====
// pve_ctrl: sequencer of the velocity estimator, issues one datapath op at a time
// depends on pve_pkg for the state and op enums and the status struct
`default_nettype none

module pve_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_tvalid,
   output logic                    req_tready,
   input  pve_pkg::pve_status_type status,
   output pve_pkg::pve_op_type     op
);
   import pve_pkg::*;

   pve_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      op         = OP_NONE;
      req_tready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               op       = OP_LOAD;
               state_in = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            if (status.first_case) begin
               op       = OP_FIRST;
               state_in = ST_FINISH;
            end else if (status.dt_zero) begin
               state_in = ST_SQ_X;
            end else if (status.tau_zero) begin
               op       = OP_K_ONE;
               state_in = ST_V_MUL;
            end else begin
               op       = OP_START_R;
               state_in = ST_R_WAIT;
            end
         end
         ST_R_WAIT: begin
            if (status.div_done) begin
               if (status.r_big) begin
                  op       = OP_K_ONE;
                  state_in = ST_V_MUL;
               end else begin
                  op       = OP_R_TAKE;
                  state_in = ST_T_MUL;
               end
            end
         end
         ST_T_MUL: begin
            op       = OP_T_MUL;
            state_in = ST_T_MUL_W;
         end
         ST_T_MUL_W: begin
            if (status.mul_done) begin
               op       = OP_T_DIV;
               state_in = ST_T_DIV_W;
            end
         end
         ST_T_DIV_W: begin
            if (status.div_done) begin
               op       = OP_T_ACC;
               state_in = status.terms_last ? ST_E_INIT : ST_T_MUL;
            end
         end
         ST_E_INIT: begin
            op       = OP_E_INIT;
            state_in = ST_E_CHK;
         end
         ST_E_CHK: begin
            if (status.n_zero) begin
               op       = OP_K_CALC;
               state_in = ST_V_MUL;
            end else begin
               op       = OP_E_MUL;
               state_in = ST_E_MUL_W;
            end
         end
         ST_E_MUL_W: begin
            if (status.mul_done) begin
               op       = OP_E_TAKE;
               state_in = ST_E_CHK;
            end
         end
         ST_V_MUL: begin
            op       = OP_V_MUL;
            state_in = ST_V_MUL_W;
         end
         ST_V_MUL_W: begin
            if (status.mul_done) begin
               op       = OP_V_DIV;
               state_in = ST_V_DIV_W;
            end
         end
         ST_V_DIV_W: begin
            if (status.div_done) begin
               op       = OP_B_MUL;
               state_in = ST_B_MUL_W;
            end
         end
         ST_B_MUL_W: begin
            if (status.mul_done) begin
               op       = OP_B_UPD;
               state_in = status.axis_y ? ST_SQ_X : ST_V_MUL;
            end
         end
         ST_SQ_X: begin
            op       = OP_SQ_X;
            state_in = ST_SQ_X_W;
         end
         ST_SQ_X_W: begin
            if (status.mul_done) begin
               op       = OP_SQ_Y;
               state_in = ST_SQ_Y_W;
            end
         end
         ST_SQ_Y_W: begin
            if (status.mul_done) begin
               op       = OP_SQRT;
               state_in = ST_SQRT_W;
            end
         end
         ST_SQRT_W: begin
            if (status.sqrt_done) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (status.out_free) begin
               op       = OP_FINISH;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

`default_nettype wire

// ===== hw/rtl/pve_dp.sv =====
// pve_dp: datapath of the velocity estimator: state, registers, result register
// depends on pve_pkg, pve_mul, pve_div and pve_sqrt
`default_nettype none

module pve_dp #(
   parameter int POS_BITS  = 16,
   parameter int TIME_BITS = 16
) (
   input  logic                             clock,
   input  logic                             reset,
   input  pve_pkg::pve_op_type              op,
   output pve_pkg::pve_status_type          status,
   input  logic signed [POS_BITS-1:0]       pos_x,
   input  logic signed [POS_BITS-1:0]       pos_y,
   input  logic [TIME_BITS-1:0]             elapsed,
   input  logic                             restart,
   input  logic                             csr_valid,
   input  logic [pve_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [pve_pkg::CSR_DAT_W-1:0]    csr_data,
   input  logic                             rsp_tready,
   output logic                             rsp_tvalid,
   output logic [pve_pkg::SPEED_W-1:0]      speed,
   output logic [pve_pkg::VEL_W-1:0]        vel_x_out,
   output logic [pve_pkg::VEL_W-1:0]        vel_y_out,
   output logic                             first_sample
);
   import pve_pkg::*;

   localparam int DTW = (TIME_BITS > CSR_DAT_W) ? TIME_BITS : CSR_DAT_W;
   localparam int DPW = POS_BITS + 1;
   localparam int MAW = (DPW > VEL_W + 1) ? DPW : VEL_W + 1;
   localparam int MBW = VEL_W + 1;
   localparam int PW  = MAW + MBW;
   localparam int DV0 = (DTW + 16 > POS_BITS + 24) ? DTW + 16 : POS_BITS + 24;
   localparam int DVW = (DV0 > 33) ? DV0 : 33;
   localparam int DSW = DTW + 1;
   localparam int QXW = (DVW > VEL_W) ? DVW : VEL_W;

   // configuration
   logic [CSR_DAT_W-1:0] nft_ff, nft_in;
   logic [CSR_DAT_W-1:0] tau_ff, tau_in;

   // tracking state
   logic                       tracking_ff, tracking_in;
   logic signed [POS_BITS-1:0] last_x_ff, last_x_in;
   logic signed [POS_BITS-1:0] last_y_ff, last_y_in;
   logic [VEL_W-1:0]           vx_ff, vx_in;
   logic [VEL_W-1:0]           vy_ff, vy_in;

   // latched item and working registers
   logic signed [POS_BITS-1:0] x_ff, x_in;
   logic signed [POS_BITS-1:0] y_ff, y_in;
   logic                       restart_ff, restart_in;
   logic [DTW-1:0]             dt_ff, dt_in;
   logic [31:0]                xq_ff, xq_in;
   logic [32:0]                term_ff, term_in;
   logic signed [34:0]         sum_ff, sum_in;
   logic [3:0]                 i_ff, i_in;
   logic [3:0]                 n_ff, n_in;
   logic [32:0]                e_ff, e_in;
   logic [16:0]                k_ff, k_in;
   logic                       axis_ff, axis_in;
   logic                       dneg_ff, dneg_in;
   logic                       diffneg_ff, diffneg_in;
   logic [79:0]                sq_ff, sq_in;
   logic                       first_ff, first_in;

   // result register
   logic                       out_valid_ff, out_valid_in;
   logic [SPEED_W-1:0]         speed_ff, speed_in;
   logic [VEL_W-1:0]           ovx_ff, ovx_in;
   logic [VEL_W-1:0]           ovy_ff, ovy_in;
   logic                       ofirst_ff, ofirst_in;

   // shared units
   logic           mul_start, mul_done;
   logic [MAW-1:0] mul_a;
   logic [MBW-1:0] mul_b;
   logic [PW-1:0]  prod;
   logic           div_start, div_done;
   logic [DVW-1:0] div_n;
   logic [DSW-1:0] div_d;
   logic [DVW-1:0] quo;
   logic           sqrt_start, sqrt_done;
   logic [SQRT_RAD_W-1:0]  rad;
   logic [SQRT_ROOT_W-1:0] root;

   // combinational helpers
   logic signed [DPW-1:0] d_sel;
   logic [DPW-1:0]        d_mag;
   logic [VEL_W-1:0]      v_sel;
   logic [QXW-1:0]        q_ext;
   logic [SPEED_W-1:0]    q_sat;
   logic signed [VEL_W:0] target;
   logic signed [VEL_W:0] diff;
   logic [VEL_W:0]        diff_mag;
   logic [64:0]           e_round;
   logic [33:0]           k_round;
   logic [57:0]           b_round;
   logic [VEL_W-1:0]      b_step;
   logic [VEL_W-1:0]      vx_mag;
   logic [VEL_W-1:0]      vy_mag;
   logic [SPEED_W-1:0]    root_sat;

   pve_mul #(.AW(MAW), .BW(MBW)) u_mul (
      .clock (clock),
      .reset (reset),
      .start (mul_start),
      .a     (mul_a),
      .b     (mul_b),
      .done  (mul_done),
      .prod  (prod)
   );

   pve_div #(.NW(DVW), .DW(DSW)) u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (div_n),
      .den   (div_d),
      .done  (div_done),
      .quo   (quo)
   );

   pve_sqrt #(.RW(SQRT_RAD_W)) u_sqrt (
      .clock (clock),
      .reset (reset),
      .start (sqrt_start),
      .rad   (rad),
      .done  (sqrt_done),
      .root  (root)
   );

   always_comb begin
      d_sel    = axis_ff ? (DPW'(y_ff) - DPW'(last_y_ff)) : (DPW'(x_ff) - DPW'(last_x_ff));
      d_mag    = d_sel[DPW-1] ? DPW'(-d_sel) : DPW'(d_sel);
      v_sel    = axis_ff ? vy_ff : vx_ff;
      q_ext    = QXW'(quo);
      q_sat    = (q_ext > QXW'(SPEED_MAX)) ? SPEED_MAX : q_ext[SPEED_W-1:0];
      target   = dneg_ff ? -$signed({2'b00, q_sat}) : $signed({2'b00, q_sat});
      diff     = target - $signed({v_sel[VEL_W-1], v_sel});
      diff_mag = diff[VEL_W] ? (VEL_W+1)'(-diff) : (VEL_W+1)'(diff);
      e_round  = {1'b0, prod[63:0]} + (65'd1 << 31);
      k_round  = {1'b0, e_ff} + 34'd32768;
      b_round  = {1'b0, prod[56:0]} + 58'd32768;
      b_step   = b_round[VEL_W+15:16];
      vx_mag   = vx_ff[VEL_W-1] ? (~vx_ff + VEL_W'(1)) : vx_ff;
      vy_mag   = vy_ff[VEL_W-1] ? (~vy_ff + VEL_W'(1)) : vy_ff;
      root_sat = (root > SQRT_ROOT_W'(SPEED_MAX)) ? SPEED_MAX : root[SPEED_W-1:0];
   end

   // unit operands
   always_comb begin
      mul_start  = 1'b0;
      mul_a      = '0;
      mul_b      = '0;
      div_start  = 1'b0;
      div_n      = '0;
      div_d      = '0;
      sqrt_start = 1'b0;
      rad        = SQRT_RAD_W'(sq_ff) + SQRT_RAD_W'(prod[79:0]);
      case (op)
         OP_START_R: begin
            div_start = 1'b1;
            div_n     = DVW'({dt_ff, 16'h0000});
            div_d     = DSW'(tau_ff);
         end
         OP_T_MUL: begin
            mul_start = 1'b1;
            mul_a     = MAW'(term_ff);
            mul_b     = MBW'(xq_ff);
         end
         OP_T_DIV: begin
            div_start = 1'b1;
            div_n     = DVW'(prod[63:32]);
            div_d     = DSW'(i_ff);
         end
         OP_E_MUL: begin
            mul_start = 1'b1;
            mul_a     = MAW'(e_ff);
            mul_b     = MBW'(E1_Q32);
         end
         OP_V_MUL: begin
            mul_start = 1'b1;
            mul_a     = MAW'(d_mag);
            mul_b     = MBW'(INST_SCALE);
         end
         OP_V_DIV: begin
            div_start = 1'b1;
            div_n     = DVW'({prod[POS_BITS+22:0], 1'b0}) + DVW'(dt_ff);
            div_d     = {dt_ff, 1'b0};
         end
         OP_B_MUL: begin
            mul_start = 1'b1;
            mul_a     = MAW'(diff_mag);
            mul_b     = MBW'(k_ff);
         end
         OP_SQ_X: begin
            mul_start = 1'b1;
            mul_a     = MAW'(vx_mag);
            mul_b     = MBW'(vx_mag);
         end
         OP_SQ_Y: begin
            mul_start = 1'b1;
            mul_a     = MAW'(vy_mag);
            mul_b     = MBW'(vy_mag);
         end
         OP_SQRT: begin
            sqrt_start = 1'b1;
         end
         default: begin
         end
      endcase
   end

   // register updates
   always_comb begin
      nft_in       = nft_ff;
      tau_in       = tau_ff;
      tracking_in  = tracking_ff;
      last_x_in    = last_x_ff;
      last_y_in    = last_y_ff;
      vx_in        = vx_ff;
      vy_in        = vy_ff;
      x_in         = x_ff;
      y_in         = y_ff;
      restart_in   = restart_ff;
      dt_in        = dt_ff;
      xq_in        = xq_ff;
      term_in      = term_ff;
      sum_in       = sum_ff;
      i_in         = i_ff;
      n_in         = n_ff;
      e_in         = e_ff;
      k_in         = k_ff;
      axis_in      = axis_ff;
      dneg_in      = dneg_ff;
      diffneg_in   = diffneg_ff;
      sq_in        = sq_ff;
      speed_in     = speed_ff;
      ovx_in       = ovx_ff;
      ovy_in       = ovy_ff;
      first_in     = first_ff;
      ofirst_in    = ofirst_ff;
      out_valid_in = out_valid_ff & ~rsp_tready;

      if (csr_valid) begin
         case (csr_index)
            CSR_NOMINAL_FRAME_TIME:     nft_in = csr_data;
            CSR_VELOCITY_TIME_CONSTANT: tau_in = csr_data;
            default: begin
            end
         endcase
      end

      case (op)
         OP_LOAD: begin
            x_in       = pos_x;
            y_in       = pos_y;
            restart_in = restart;
            dt_in      = (elapsed != '0) ? DTW'(elapsed) : DTW'(nft_ff);
            axis_in    = 1'b0;
            first_in   = 1'b0;
         end
         OP_FIRST: begin
            vx_in       = '0;
            vy_in       = '0;
            tracking_in = 1'b1;
            first_in    = 1'b1;
         end
         OP_K_ONE: begin
            k_in = K_ONE;
         end
         OP_R_TAKE: begin
            xq_in   = {quo[15:0], 16'h0000};
            n_in    = quo[19:16];
            term_in = 33'h1_0000_0000;
            sum_in  = 35'sh1_0000_0000;
            i_in    = 4'd1;
         end
         OP_T_ACC: begin
            term_in = quo[32:0];
            // odd terms of the series subtract
            if (i_ff[0]) begin
               sum_in = sum_ff - $signed({2'b00, quo[32:0]});
            end else begin
               sum_in = sum_ff + $signed({2'b00, quo[32:0]});
            end
            i_in = i_ff + 4'd1;
         end
         OP_E_INIT: begin
            if (sum_ff < 0) begin
               e_in = '0;
            end else if (sum_ff > 35'sh1_0000_0000) begin
               e_in = 33'h1_0000_0000;
            end else begin
               e_in = sum_ff[32:0];
            end
         end
         OP_E_TAKE: begin
            e_in = e_round[64:32];
            n_in = n_ff - 4'd1;
         end
         OP_K_CALC: begin
            k_in = K_ONE - k_round[32:16];
         end
         OP_V_MUL: begin
            dneg_in = d_sel[DPW-1];
         end
         OP_B_MUL: begin
            diffneg_in = diff[VEL_W];
         end
         OP_B_UPD: begin
            // the blend stays between the old and the target velocity, so mod 2^40 is exact
            if (axis_ff) begin
               vy_in = diffneg_ff ? (vy_ff - b_step) : (vy_ff + b_step);
            end else begin
               vx_in = diffneg_ff ? (vx_ff - b_step) : (vx_ff + b_step);
            end
            axis_in = ~axis_ff;
         end
         OP_SQ_Y: begin
            sq_in = prod[79:0];
         end
         OP_FINISH: begin
            speed_in     = first_ff ? '0 : root_sat;
            ovx_in       = vx_ff;
            ovy_in       = vy_ff;
            ofirst_in    = first_ff;
            last_x_in    = x_ff;
            last_y_in    = y_ff;
            out_valid_in = 1'b1;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         nft_ff       <= NFT_RESET;
         tau_ff       <= TAU_RESET;
         tracking_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         nft_ff       <= nft_in;
         tau_ff       <= tau_in;
         tracking_ff  <= tracking_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      last_x_ff  <= last_x_in;
      last_y_ff  <= last_y_in;
      vx_ff      <= vx_in;
      vy_ff      <= vy_in;
      x_ff       <= x_in;
      y_ff       <= y_in;
      restart_ff <= restart_in;
      dt_ff      <= dt_in;
      xq_ff      <= xq_in;
      term_ff    <= term_in;
      sum_ff     <= sum_in;
      i_ff       <= i_in;
      n_ff       <= n_in;
      e_ff       <= e_in;
      k_ff       <= k_in;
      axis_ff    <= axis_in;
      dneg_ff    <= dneg_in;
      diffneg_ff <= diffneg_in;
      sq_ff      <= sq_in;
      first_ff   <= first_in;
      speed_ff   <= speed_in;
      ovx_ff     <= ovx_in;
      ovy_ff     <= ovy_in;
      ofirst_ff  <= ofirst_in;
   end

   always_comb begin
      status.first_case = ~tracking_ff | restart_ff;
      status.dt_zero    = (dt_ff == '0);
      status.tau_zero   = (tau_ff == '0);
      status.r_big      = (QXW'(quo) >= QXW'(R_LIMIT));
      status.terms_last = (i_ff == TERM_LAST);
      status.n_zero     = (n_ff == '0);
      status.axis_y     = axis_ff;
      status.mul_done   = mul_done;
      status.div_done   = div_done;
      status.sqrt_done  = sqrt_done;
      status.out_free   = ~out_valid_ff | rsp_tready;
   end

   assign rsp_tvalid   = out_valid_ff;
   assign speed        = speed_ff;
   assign vel_x_out    = ovx_ff;
   assign vel_y_out    = ovy_ff;
   assign first_sample = ofirst_ff;

endmodule

`default_nettype wire

// ===== hw/rtl/pve_checker.sv =====
// pve_checker: port-level assertions for pointer_velocity_ema, bound to the top level
// watches the handshake and result ports only; no package use
`default_nettype none

module pve_checker (
   input logic         clock,
   input logic         reset,
   input logic         req_tvalid,
   input logic         req_tready,
   input logic         rsp_tvalid,
   input logic         rsp_tready,
   input logic [119:0] rsp_tdata,
   input logic         rsp_tuser
);

   // one item at a time: busy right after an accepted item
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("input ready straight after an accepted item");

   // a start item reports zero speed and zero velocity
   a_first_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tdata == 120'd0)
      else $error("start item with nonzero result");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("result dropped while stalled");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("result changed while stalled");

endmodule

bind pointer_velocity_ema pve_checker u_pve_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);

`default_nettype wire

// ===== dv/pointer_velocity_ema_test.sv =====
// pointer_velocity_ema_test: self-checking bench for the smoothed pointer velocity estimator
// drives position items with random gaps, predicts velocity and speed, checks every result
// depends on pve_pkg and pointer_velocity_ema
`timescale 1ns / 1ps

class velocity_scoreboard;
   bit [15:0] frame_time;
   bit [15:0] tau;
   bit        tracking;
   longint    last_x, last_y, vx, vy;
   bit [38:0] want_speed[$];
   bit [39:0] want_vx[$];
   bit [39:0] want_vy[$];
   bit        want_first[$];
   int        errors;

   function new();
      frame_time = pve_pkg::NFT_RESET;
      tau        = pve_pkg::TAU_RESET;
      tracking   = 0;
      last_x = 0; last_y = 0; vx = 0; vy = 0;
      errors = 0;
   endfunction

   function void set_reg(bit [7:0] idx, bit [15:0] val);
      if (idx == pve_pkg::CSR_NOMINAL_FRAME_TIME) frame_time = val;
      else if (idx == pve_pkg::CSR_VELOCITY_TIME_CONSTANT) tau = val;
   endfunction

   function bit [63:0] mag(longint v);
      return v < 0 ? -v : v;
   endfunction

   function bit [63:0] exp_part(bit [63:0] xq);
      bit [63:0] term;
      longint    acc;
      term = 64'd1 << 32;
      acc  = 64'd1 << 32;
      for (int i = 1; i <= 12; i++) begin
         term = ((term * xq) >> 32) / i;
         if (i % 2) acc -= term;
         else acc += term;
      end
      if (acc < 0) acc = 0;
      if (acc > (64'd1 << 32)) acc = 64'd1 << 32;
      return acc;
   endfunction

   function bit [63:0] blend_factor(bit [63:0] dt);
      bit [63:0] r, e;
      if (tau == 0) return 65536;
      r = (dt << 16) / tau;
      if (r >= (64'd12 << 16)) return 65536;
      e = exp_part((r & 64'hFFFF) << 16);
      for (int n = r >> 16; n > 0; n--)
         e = (e * pve_pkg::E1_Q32 + (64'd1 << 31)) >> 32;
      return 65536 - ((e + 32768) >> 16);
   endfunction

   function longint pixel_rate(longint d, bit [63:0] dt);
      bit [63:0] q;
      longint    v;
      q = (2 * mag(d) * 4096000 + dt) / (2 * dt);
      v = q > 64'h7F_FFFF_FFFF ? 64'h7F_FFFF_FFFF : q;
      return d < 0 ? -v : v;
   endfunction

   function longint smooth(longint v, longint target, bit [63:0] k);
      longint    p;
      bit [63:0] m;
      p = (target - v) * longint'(k);
      m = (mag(p) + 32768) >> 16;
      return p < 0 ? v - longint'(m) : v + longint'(m);
   endfunction

   function void note_sample(bit [15:0] px, bit [15:0] py, bit [15:0] el, bit rst);
      longint    x, y;
      bit [63:0] dt, k;
      bit [127:0] sq, root, c;
      bit        first;
      x = longint'($signed(px));
      y = longint'($signed(py));
      dt = el;
      first = 0;
      if (!tracking || rst) begin
         vx = 0; vy = 0; tracking = 1; first = 1;
      end else begin
         if (dt == 0) dt = frame_time;
         if (dt != 0) begin
            k  = blend_factor(dt);
            vx = smooth(vx, pixel_rate(x - last_x, dt), k);
            vy = smooth(vy, pixel_rate(y - last_y, dt), k);
         end
      end
      last_x = x; last_y = y;
      sq = 128'(mag(vx)) * mag(vx) + 128'(mag(vy)) * mag(vy);
      root = 0;
      for (int b = 40; b >= 0; b--) begin
         c = root | (128'd1 << b);
         if (c * c <= sq) root = c;
      end
      if (root > pve_pkg::SPEED_MAX) root = pve_pkg::SPEED_MAX;
      want_speed.push_back(first ? 39'd0 : root[38:0]);
      want_vx.push_back(vx[39:0]);
      want_vy.push_back(vy[39:0]);
      want_first.push_back(first);
   endfunction

   function void check_result(bit [119:0] d, bit u);
      bit [38:0] s;
      bit [39:0] ex, ey;
      bit        f;
      if (want_first.size() == 0) begin
         $display("%0t: unexpected result %h", $time, d);
         errors++;
         return;
      end
      s = want_speed.pop_front(); ex = want_vx.pop_front();
      ey = want_vy.pop_front(); f = want_first.pop_front();
      if (d[38:0] !== s) begin
         $display("%0t: speed expected %h actual %h", $time, s, d[38:0]); errors++;
      end
      if (d[78:39] !== ex) begin
         $display("%0t: vel_x expected %h actual %h", $time, ex, d[78:39]); errors++;
      end
      if (d[118:79] !== ey) begin
         $display("%0t: vel_y expected %h actual %h", $time, ey, d[118:79]); errors++;
      end
      if (d[119] !== 1'b0) begin
         $display("%0t: pad expected 0 actual %b", $time, d[119]); errors++;
      end
      if (u !== f) begin
         $display("%0t: first_sample expected %b actual %b", $time, f, u); errors++;
      end
   endfunction

   function int pending();
      return want_first.size();
   endfunction
endclass

module pointer_velocity_ema_test;
   import pve_pkg::*;

   localparam int STALL_LIMIT = 20000;

   logic         clock = 0;
   logic         reset = 1;
   logic         req_tvalid = 0;
   logic         req_tready;
   logic [47:0]  req_tdata = '0;
   logic         req_tuser = 0;
   logic         rsp_tvalid;
   logic         rsp_tready = 0;
   logic [119:0] rsp_tdata;
   logic         rsp_tuser;
   logic         csr_valid = 0;
   logic         csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [CSR_DAT_W-1:0] csr_data = '0;

   velocity_scoreboard board = new();
   int  idle_cycles = 0;
   bit  rsp_stall_on = 1;
   bit  req_gap_on = 1;

   pointer_velocity_ema DUT (.*);

   always #5 clock = ~clock;

   function int gap_length();
      if ($urandom_range(9) < 7) return $urandom_range(2);
      return $urandom_range(40);
   endfunction

   // result side: sample at rising edge, move ready at falling edge
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) board.check_result(rsp_tdata, rsp_tuser);
   end

   initial begin
      int n;
      @(negedge clock);
      while (1) begin
         n = rsp_stall_on ? gap_length() : 0;
         if (n > 0) begin
            rsp_tready <= 0;
            repeat (n) @(negedge clock);
         end
         rsp_tready <= 1;
         @(negedge clock);
      end
   end

   // watchdog on accepted traffic
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || reset)
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
         $display("pointer_velocity_ema_test: done, errors");
         $finish;
      end
   end

   task send_sample(bit [15:0] px, bit [15:0] py, bit [15:0] el, bit rst);
      int n;
      n = req_gap_on ? gap_length() : 0;
      repeat (n + 1) @(negedge clock);
      req_tvalid <= 1;
      req_tdata  <= {el, py, px};
      req_tuser  <= rst;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      board.note_sample(px, py, el, rst);
      @(negedge clock);
      req_tvalid <= 0;
   endtask

   task drain();
      while (board.pending() != 0) @(negedge clock);
      repeat (2100) @(negedge clock);
   endtask

   task write_reg(bit [7:0] idx, bit [15:0] val);
      @(negedge clock);
      csr_valid <= 1;
      csr_index <= idx;
      csr_data  <= val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      board.set_reg(idx, val);
      @(negedge clock);
      csr_valid <= 0;
   endtask

   task random_run(int count);
      bit [15:0] px, py;
      for (int i = 0; i < count; i++) begin
         case ($urandom_range(9))
            0: begin px = 16'($urandom); py = 16'($urandom); end
            default: begin
               px = 16'(board.last_x + $signed($urandom_range(400)) - 200);
               py = 16'(board.last_y + $signed($urandom_range(400)) - 200);
            end
         endcase
         send_sample(px, py,
            $urandom_range(9) == 0 ? 16'($urandom) :
            ($urandom_range(7) == 0 ? 16'd0 : 16'($urandom_range(600))),
            $urandom_range(29) == 0);
      end
   endtask

   initial begin
      repeat (7) @(negedge clock);
      reset <= 0;
      @(negedge clock);

      // directed: start, extremes, restart
      send_sample(16'h0000, 16'h0000, 16'd0, 0);
      send_sample(16'h7FFF, 16'h8000, 16'd1, 0);
      send_sample(16'h8000, 16'h7FFF, 16'd1, 0);
      send_sample(16'h8000, 16'h7FFF, 16'hFFFF, 0);
      send_sample(16'h0010, 16'hFFF0, 16'd0, 0);
      send_sample(16'h1234, 16'h4321, 16'd200, 1);
      send_sample(16'h1240, 16'h4300, 16'd267, 0);
      send_sample(16'h1250, 16'h4310, 16'd9600, 0);
      send_sample(16'h5555, 16'hAAAA, 16'hAAAA, 0);
      send_sample(16'hAAAA, 16'h5555, 16'h5555, 0);
      drain();

      // no smoothing, frame time zero: both times zero keeps velocity
      write_reg(CSR_VELOCITY_TIME_CONSTANT, 16'd0);
      write_reg(CSR_NOMINAL_FRAME_TIME, 16'd0);
      send_sample(16'h0100, 16'h0100, 16'd16, 0);
      send_sample(16'h0180, 16'h0000, 16'd16, 0);
      send_sample(16'h0200, 16'hFF00, 16'd0, 0);
      send_sample(16'h7FFF, 16'h7FFF, 16'd1, 0);
      send_sample(16'h8000, 16'h8000, 16'd1, 0);
      send_sample(16'h8000, 16'h8000, 16'd0, 0);
      random_run(60);
      drain();

      // back-to-back samples with no result stalls, at maximum frame time and time constant
      write_reg(CSR_NOMINAL_FRAME_TIME, 16'hFFFF);
      write_reg(CSR_VELOCITY_TIME_CONSTANT, 16'hFFFF);
      rsp_stall_on = 0;
      req_gap_on = 0;
      random_run(80);
      drain();
      rsp_stall_on = 1;
      req_gap_on = 1;

      write_reg(CSR_NOMINAL_FRAME_TIME, 16'd1);
      write_reg(CSR_VELOCITY_TIME_CONSTANT, 16'd1);
      random_run(80);
      drain();

      for (int ph = 0; ph < 4; ph++) begin
         write_reg(CSR_NOMINAL_FRAME_TIME, 16'($urandom));
         write_reg(CSR_VELOCITY_TIME_CONSTANT, 16'($urandom_range(4000)));
         write_reg(8'(2 + $urandom_range(200)), 16'($urandom));
         random_run(95);
         drain();
      end

      if (board.errors == 0)
         $display("pointer_velocity_ema_test: done, clean");
      else
         $display("pointer_velocity_ema_test: done, errors");
      $finish;
   end
endmodule
